// ----- hw/rtl/uvs_pkg.sv -----
// Shared types and constants of the UV sphere tessellator.
package uvs_pkg;

    localparam logic [1:0] CFG_COLUMNS     = 2'd0;
    localparam logic [1:0] CFG_RINGS       = 2'd1;
    localparam logic [1:0] CFG_COLUMN_STEP = 2'd2;
    localparam logic [1:0] CFG_RING_STEP   = 2'd3;

    localparam logic OP_VERTEX = 1'b0;
    localparam logic OP_FACE   = 1'b1;

    localparam logic [8:0]  RST_COLUMNS     = 9'd16;
    localparam logic [8:0]  RST_RINGS       = 9'd9;
    localparam logic [15:0] RST_COLUMN_STEP = 16'd4096;
    localparam logic [15:0] RST_RING_STEP   = 16'd4096;

    localparam logic [14:0] QUARTER = 15'd16384;

    // Taylor coefficients of sin(pi/2 * u) in Q30
    localparam logic [30:0] CA1 = 31'd1686629713;
    localparam logic [30:0] CA3 = 31'd693598668;
    localparam logic [30:0] CA5 = 31'd85569306;
    localparam logic [30:0] CA7 = 31'd5026998;
    localparam logic [30:0] CA9 = 31'd172272;

    typedef struct packed {
        logic       operation;
        logic [7:0] row;
        logic [7:0] column;
        logic       half;
    } t_req;

    typedef struct packed {
        logic               valid_res;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [15:0]        corner_a;
        logic [15:0]        corner_b;
        logic [15:0]        corner_c;
    } t_res;

    // Fold a turn angle into a quarter-wave argument 0..16384
    function automatic logic [14:0] fold_angle(input logic [15:0] a);
        logic [14:0] f;
        f = {1'b0, a[13:0]};
        fold_angle = a[14] ? (QUARTER - f) : f;
    endfunction

endpackage

// ----- hw/rtl/uv_sphere_tessellator.sv -----
// UV sphere tessellator: one vertex position or face triple per beat.
// Pipeline: prep register, seven sine stages, multiply register, output register.
// Throughput: one beat per cycle while the output does not stall; the four 7-stage polynomial sine pipes set the depth.
// A stall at the output holds the whole pipeline; nothing is dropped or repeated.
// Synchronous active-low reset clears the valid bits and loads the default registers.
module uv_sphere_tessellator #(
    parameter int MAX_RESOLUTION = 256,
    parameter int FRACTION_BITS  = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  uvs_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output uvs_pkg::t_res o_res,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data
);
    import uvs_pkg::*;

    // side-band delay: the prep register plus the seven sine stages
    localparam int QLAT = 8;
    localparam int FB   = FRACTION_BITS;
    localparam logic [2*FB+1:0] MRND = (2*FB+2)'(1) << (FB - 1);

    typedef struct packed {
        logic        vld;
        logic        ok;
        logic        op;
        logic        neg_sv;
        logic        neg_cv;
        logic        neg_sh;
        logic        neg_ch;
        logic [15:0] ca;
        logic [15:0] cb;
        logic [15:0] cc;
    } t_side;

    logic [8:0]  r_columns, r_rings;
    logic [15:0] r_col_step, r_ring_step;

    logic        en;
    t_side       n_side;
    t_side       r_dly [0:QLAT-1];
    t_side       r_m_side;
    logic [14:0] n_t [0:3];
    logic [14:0] r_t [0:3];
    logic [FB:0] sin_o [0:3];
    logic [FB:0] r_mx, r_my, r_mz;
    logic        r_out_vld;
    t_res        r_out;
    t_res        n_out;

    // prep stage
    logic        res_ok, pole, v_ok, f_ok, fan;
    logic [8:0]  row9, col9, nxt;
    logic [7:0]  s;
    logic [17:0] sc, base0, base1;
    logic [23:0] va_full, ha_full;
    logic [15:0] va, ha, vac, hac;
    logic [2*FB+1:0] px, py;

    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    always_comb begin
        row9    = {1'b0, i_req.row};
        col9    = {1'b0, i_req.column};
        res_ok  = (r_columns >= 9'd3) && (32'(r_columns) <= MAX_RESOLUTION)
               && (r_rings >= 9'd3) && (32'(r_rings) <= MAX_RESOLUTION);
        pole    = (i_req.row == 8'd0) || (row9 == r_rings - 9'd1);
        v_ok    = (row9 < r_rings) && (pole ? (i_req.column == 8'd0) : (col9 < r_columns));
        fan     = (i_req.row == 8'd0) || (row9 == r_rings - 9'd2);
        f_ok    = (row9 < r_rings - 9'd1) && (col9 < r_columns) && !(fan && i_req.half);
        nxt     = (col9 + 9'd1 == r_columns) ? 9'd0 : col9 + 9'd1;
        s       = i_req.row - 8'd1;
        sc      = 18'(s) * 18'(r_columns);
        base0   = 18'd1 + sc;
        base1   = base0 + 18'(r_columns);
        va_full = r_ring_step * i_req.row;
        ha_full = r_col_step * i_req.column;
        va      = va_full[15:0];
        ha      = ha_full[15:0];
        vac     = va + 16'(QUARTER);
        hac     = ha + 16'(QUARTER);
        n_t[0]  = fold_angle(va);
        n_t[1]  = fold_angle(vac);
        n_t[2]  = fold_angle(ha);
        n_t[3]  = fold_angle(hac);

        n_side        = '0;
        n_side.vld    = i_valid;
        n_side.op     = i_req.operation;
        n_side.ok     = res_ok && ((i_req.operation == OP_FACE) ? f_ok : v_ok);
        n_side.neg_sv = va[15];
        n_side.neg_cv = vac[15];
        n_side.neg_sh = ha[15];
        n_side.neg_ch = hac[15];
        if ((i_req.operation == OP_FACE) && n_side.ok) begin
            if (i_req.row == 8'd0) begin
                n_side.ca = 16'd0;
                n_side.cb = 16'(col9 + 9'd1);
                n_side.cc = 16'(nxt + 9'd1);
            end else if (row9 == r_rings - 9'd2) begin
                n_side.ca = base1[15:0];
                n_side.cb = 16'(base0 + 18'(col9));
                n_side.cc = 16'(base0 + 18'(nxt));
            end else begin
                n_side.ca = 16'(base0 + 18'(col9));
                n_side.cb = i_req.half ? 16'(base1 + 18'(col9)) : 16'(base0 + 18'(nxt));
                n_side.cc = 16'(base1 + 18'(nxt));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns   <= RST_COLUMNS;
            r_rings     <= RST_RINGS;
            r_col_step  <= RST_COLUMN_STEP;
            r_ring_step <= RST_RING_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLUMNS:     r_columns   <= i_cfg_data[8:0];
                CFG_RINGS:       r_rings     <= i_cfg_data[8:0];
                CFG_COLUMN_STEP: r_col_step  <= i_cfg_data;
                CFG_RING_STEP:   r_ring_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sine pipes read the prep registers
    for (genvar g = 0; g < 4; g++) begin : g_sine
        uvs_qsine #(.FRACTION_BITS(FRACTION_BITS)) u_qsine (
            .i_clk (i_clk),
            .i_en  (en),
            .i_t   (r_t[g]),
            .o_s   (sin_o[g])
        );
    end

    // sin_o: 0 sin(v), 1 cos(v), 2 sin(h), 3 cos(h)
    always_comb begin
        px = (2*FB+2)'(sin_o[0]) * (2*FB+2)'(sin_o[3]) + MRND;
        py = (2*FB+2)'(sin_o[0]) * (2*FB+2)'(sin_o[2]) + MRND;
    end

    function automatic logic [15:0] to16(input logic [FB:0] m, input logic neg);
        to16 = neg ? (16'd0 - 16'(m)) : 16'(m);
    endfunction

    always_comb begin
        n_out           = '0;
        n_out.valid_res = r_m_side.ok;
        if (r_m_side.ok && (r_m_side.op == OP_VERTEX)) begin
            n_out.pos_x = to16(r_mx, r_m_side.neg_sv ^ r_m_side.neg_ch);
            n_out.pos_y = to16(r_my, r_m_side.neg_sv ^ r_m_side.neg_sh);
            n_out.pos_z = to16(r_mz, r_m_side.neg_cv);
        end
        n_out.corner_a = r_m_side.ca;
        n_out.corner_b = r_m_side.cb;
        n_out.corner_c = r_m_side.cc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_rst: for (int k = 0; k < QLAT; k++) begin
                r_dly[k].vld <= 1'b0;
            end
            r_m_side.vld <= 1'b0;
            r_out_vld    <= 1'b0;
        end else if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_t[k] <= n_t[k];
            end
            r_dly[0] <= n_side;
            for (int k = 1; k < QLAT; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
            r_m_side  <= r_dly[QLAT-1];
            r_mx      <= px[2*FB:FB];
            r_my      <= py[2*FB:FB];
            r_mz      <= sin_o[1];
            r_out_vld <= r_m_side.vld;
            r_out     <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_out;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.valid_res) |-> (o_res.pos_x == 16'd0 && o_res.pos_y == 16'd0
            && o_res.pos_z == 16'd0 && o_res.corner_a == 16'd0
            && o_res.corner_b == 16'd0 && o_res.corner_c == 16'd0))
        else $error("invalid result carries data");

    a_face_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.corner_b != 16'd0)) |-> (o_res.pos_x == 16'd0
            && o_res.pos_y == 16'd0 && o_res.pos_z == 16'd0))
        else $error("face result carries a position");

    a_stall_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (r_out_vld && i_stall))
        else $error("input stall does not follow output back-pressure");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_side.vld && o_stall) |=> r_m_side.vld)
        else $error("beat lost in mul stage under stall");

endmodule

// ----- hw/rtl/uvs_qsine.sv -----
// Seven-stage pipelined quarter-wave sine: odd Taylor polynomial in Q30.
module uvs_qsine #(
    parameter int FRACTION_BITS = 14
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [14:0]              i_t,
    output logic [FRACTION_BITS:0]   o_s
);
    import uvs_pkg::*;

    localparam int SH = 30 - FRACTION_BITS;
    localparam logic [31:0] RND = (SH > 0) ? (32'd1 << (SH - 1)) : 32'd0;
    localparam logic [FRACTION_BITS:0] FX_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    logic [29:0] r_x  [1:5];
    logic [29:0] r_x2 [1:4];
    logic [30:0] r_p  [2:5];
    logic        r_one[1:6];
    logic [30:0] r_s6;
    logic [FRACTION_BITS:0] r_s7;

    logic [29:0] n_x;
    logic [59:0] sq;
    logic [60:0] m2, m3, m4, m5, m6;
    logic [31:0] rs;
    logic [31:0] rs_sh;
    logic [FRACTION_BITS:0] n_s7;

    always_comb begin
        n_x   = {i_t[13:0], 16'd0};
        sq    = n_x * n_x;
        m2    = 61'(r_x2[1]) * 61'(CA9);
        m3    = 61'(r_x2[2]) * 61'(r_p[2]);
        m4    = 61'(r_x2[3]) * 61'(r_p[3]);
        m5    = 61'(r_x2[4]) * 61'(r_p[4]);
        m6    = 61'(r_x[5]) * 61'(r_p[5]);
        rs    = {1'b0, r_s6} + RND;
        rs_sh = rs >> SH;
        if (r_one[6]) begin
            n_s7 = FX_ONE;
        end else if (rs_sh > 32'(FX_ONE)) begin
            n_s7 = FX_ONE;
        end else begin
            n_s7 = rs_sh[FRACTION_BITS:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[1]   <= n_x;
            r_x2[1]  <= sq[59:30];
            r_one[1] <= i_t[14];
            r_p[2]   <= CA7 - m2[60:30];
            r_p[3]   <= CA5 - m3[60:30];
            r_p[4]   <= CA3 - m4[60:30];
            r_p[5]   <= CA1 - m5[60:30];
            for (int k = 2; k <= 5; k++) begin
                r_x[k] <= r_x[k-1];
            end
            for (int k = 2; k <= 4; k++) begin
                r_x2[k] <= r_x2[k-1];
            end
            for (int k = 2; k <= 6; k++) begin
                r_one[k] <= r_one[k-1];
            end
            r_s6 <= m6[60:30];
            r_s7 <= n_s7;
        end
    end

    assign o_s = r_s7;

endmodule

// ----- tb/uv_sphere_tessellator_test.sv -----
// Self-checking testbench of the UV sphere tessellator: vertex and face requests.
`timescale 1ns / 100ps

module uv_sphere_tessellator_test;
    import uvs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LATENCY = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_req        i_req = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_res        o_res;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    // shadow copy of the configuration
    logic [8:0]  mesh_columns = RST_COLUMNS;
    logic [8:0]  mesh_rings = RST_RINGS;
    logic [15:0] lon_step = RST_COLUMN_STEP;
    logic [15:0] lat_step = RST_RING_STEP;

    t_res expected_elems[$];
    int   error_count = 0;
    int   idle_cycles = 0;
    int   send_gap_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_off = 0;

    uv_sphere_tessellator u_dut (.*);

    always #6 i_clk = ~i_clk;

    // quarter-wave sine, Q30 odd polynomial, rounded to Q1.14
    function automatic longint quarter_sin(input longint unsigned t);
        longint unsigned x, x2, p, s;
        if (t >= 16384) return 64'sd16384;
        x  = t << 16;
        x2 = (x * x) >> 30;
        p  = CA7 - ((x2 * CA9) >> 30);
        p  = CA5 - ((x2 * p) >> 30);
        p  = CA3 - ((x2 * p) >> 30);
        p  = CA1 - ((x2 * p) >> 30);
        s  = (x * p) >> 30;
        s  = (s + (1 << 15)) >> 16;
        if (s > 16384) s = 16384;
        return longint'(s);
    endfunction

    function automatic longint turn_sin(input logic [15:0] a);
        longint m;
        logic [1:0] q;
        q = a[15:14];
        m = (q[0] == 1'b0) ? quarter_sin(a[13:0]) : quarter_sin(16384 - a[13:0]);
        return q[1] ? -m : m;
    endfunction

    function automatic longint scaled_product(input longint a, input longint b);
        longint unsigned ma, mb, m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m  = (ma * mb + (1 << 13)) >> 14;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic t_res mesh_element(input t_req rq);
        t_res r;
        int cc, rr, row, col, nxt, s;
        logic [15:0] va, ha;
        longint sv, cv, sh, ch;
        r = '0;
        cc = mesh_columns; rr = mesh_rings; row = rq.row; col = rq.column;
        if (cc < 3 || cc > 256 || rr < 3 || rr > 256) return r;
        if (rq.operation == OP_VERTEX) begin
            if (row >= rr) return r;
            if ((row == 0 || row == rr - 1) ? (col != 0) : (col >= cc)) return r;
            va = lat_step * rq.row;
            ha = lon_step * rq.column;
            sv = turn_sin(va); cv = turn_sin(va + 16'd16384);
            sh = turn_sin(ha); ch = turn_sin(ha + 16'd16384);
            r.valid_res = 1'b1;
            r.pos_x = 16'(scaled_product(sv, ch));
            r.pos_y = 16'(scaled_product(sv, sh));
            r.pos_z = 16'(cv);
        end else begin
            if (row >= rr - 1 || col >= cc) return r;
            nxt = (col + 1 == cc) ? 0 : col + 1;
            if (row == 0) begin
                if (rq.half) return r;
                r.corner_a = 16'd0; r.corner_b = 16'(1 + col); r.corner_c = 16'(1 + nxt);
            end else if (row == rr - 2) begin
                if (rq.half) return r;
                s = rr - 3;
                r.corner_a = 16'(1 + (rr - 2) * cc);
                r.corner_b = 16'(1 + s * cc + col);
                r.corner_c = 16'(1 + s * cc + nxt);
            end else begin
                s = row - 1;
                r.corner_a = 16'(1 + s * cc + col);
                r.corner_c = 16'(1 + (s + 1) * cc + nxt);
                r.corner_b = rq.half ? 16'(1 + (s + 1) * cc + col) : 16'(1 + s * cc + nxt);
            end
            r.valid_res = 1'b1;
        end
        return r;
    endfunction

    // leave valid high on return so beats can follow back to back
    task automatic send_request(input logic op, input int row, input int col, input logic hf);
        t_req rq;
        rq.operation = op; rq.row = 8'(row); rq.column = 8'(col); rq.half = hf;
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_req <= rq;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_elems = {expected_elems, mesh_element(rq)};
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input int value);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= 16'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_COLUMNS:     mesh_columns = 9'(value);
            CFG_RINGS:       mesh_rings = 9'(value);
            CFG_COLUMN_STEP: lon_step = 16'(value);
            default:         lat_step = 16'(value);
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (expected_elems.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic set_mesh(input int cc, input int rr);
        drain_pipeline();
        write_register(CFG_COLUMNS, cc);
        write_register(CFG_RINGS, rr);
        write_register(CFG_COLUMN_STEP, (cc == 0) ? 0 : 65536 / cc);
        write_register(CFG_RING_STEP, (rr <= 1) ? 0 : 32768 / (rr - 1));
    endtask

    task automatic test_directed();
        send_request(OP_VERTEX, 0, 0, 1'b0);
        send_request(OP_VERTEX, 0, 1, 1'b0);
        send_request(OP_VERTEX, 8, 0, 1'b1);
        send_request(OP_VERTEX, 8, 3, 1'b0);
        send_request(OP_VERTEX, 9, 0, 1'b0);
        send_request(OP_VERTEX, 4, 15, 1'b1);
        send_request(OP_VERTEX, 4, 16, 1'b0);
        send_request(OP_VERTEX, 255, 255, 1'b1);
        send_request(OP_FACE, 0, 0, 1'b0);
        send_request(OP_FACE, 0, 15, 1'b0);
        send_request(OP_FACE, 0, 3, 1'b1);
        send_request(OP_FACE, 3, 15, 1'b0);
        send_request(OP_FACE, 3, 15, 1'b1);
        send_request(OP_FACE, 7, 15, 1'b0);
        send_request(OP_FACE, 7, 2, 1'b1);
        send_request(OP_FACE, 8, 0, 1'b0);
        send_request(OP_FACE, 255, 255, 1'b1);
    endtask

    // mostly in-range requests, some just outside, some arbitrary
    task automatic random_request();
        int cc, rr, sel;
        cc = mesh_columns; rr = mesh_rings;
        sel = $urandom_range(9);
        if (sel == 0)
            send_request(1'($urandom_range(1)), $urandom_range(255), $urandom_range(255),
                         1'($urandom_range(1)));
        else if ($urandom_range(1))
            send_request(OP_VERTEX, $urandom_range((rr > 256 ? 255 : rr - 1)),
                         (sel == 1) ? 0 : $urandom_range((cc > 256 ? 255 : cc - 1)),
                         1'($urandom_range(1)));
        else
            send_request(OP_FACE, $urandom_range((rr > 256 ? 255 : rr - 1)),
                         $urandom_range((cc > 256 ? 255 : cc)), 1'($urandom_range(1)));
    endtask

    task automatic test_random(input int count);
        repeat (count) random_request();
    endtask

    task automatic test_configurations();
        set_mesh(3, 3);   test_random(40);
        set_mesh(256, 256); test_random(60);
        set_mesh(256, 256);
        write_register(CFG_COLUMN_STEP, 65535);
        write_register(CFG_RING_STEP, 32768);
        test_random(30);
        drain_pipeline();
        write_register(CFG_COLUMN_STEP, 0);
        write_register(CFG_RING_STEP, 0);
        test_random(10);
        set_mesh(2, 9);   test_random(10);
        set_mesh(16, 257); test_random(10);
        set_mesh(300, 300); test_random(10);
        set_mesh(7, 12);  test_random(40);
    endtask

    task automatic test_backpressure();
        drain_pipeline();
        send_gap_pct = 0; recv_stall_pct = 0;
        hold_off = 60;
        test_random(40);
    endtask

    task automatic test_idling();
        set_mesh(16, 9);
        send_gap_pct = 31; recv_stall_pct = 50; test_random(110);
        send_gap_pct = 50; recv_stall_pct = 31; test_random(110);
        send_gap_pct = 0;  recv_stall_pct = 0;  test_random(110);
    endtask

    // receiver stall, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_elems.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, o_res);
                error_count++;
            end else begin
                want = expected_elems.pop_front();
                if (o_res.valid_res !== want.valid_res || o_res.pos_x !== want.pos_x ||
                    o_res.pos_y !== want.pos_y || o_res.pos_z !== want.pos_z ||
                    o_res.corner_a !== want.corner_a || o_res.corner_b !== want.corner_b ||
                    o_res.corner_c !== want.corner_c) begin
                    $display("%0t: mismatch expected %h actual %h", $realtime, want, o_res);
                    error_count++;
                end
            end
        end
    end

    // end the run if no beat moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("uv_sphere_tessellator_test: errors");
            $finish;
        end
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_idling();
        test_backpressure();
        test_configurations();
        drain_pipeline();
        if (error_count == 0)
            $display("uv_sphere_tessellator_test: clean");
        else
            $display("uv_sphere_tessellator_test: errors");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/uvs_pkg.sv
hw/rtl/uvs_qsine.sv
hw/rtl/uv_sphere_tessellator.sv
tb/uv_sphere_tessellator_test.sv
